// File: hdl/text_mode_terminal_writer_assert.svh
// Assertion helpers for the terminal writer. Each macro expects clk and rst
// in the scope where it is used.
`ifndef TEXT_MODE_TERMINAL_WRITER_ASSERT_SVH
`define TEXT_MODE_TERMINAL_WRITER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TMTW_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("terminal writer check failed");

// The consequent must hold in the cycle after the antecedent.
`define TMTW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("terminal writer check failed");

`endif

// File: hdl/tmtw_pkg.sv
`default_nettype none

package tmtw_pkg;

  localparam int SCREEN_WIDTH  = 80;
  localparam int SCREEN_HEIGHT = 25;
  localparam int CELLS         = SCREEN_WIDTH * SCREEN_HEIGHT;

  localparam int ROW_W  = $clog2(SCREEN_HEIGHT);
  localparam int COL_W  = $clog2(SCREEN_WIDTH);
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CELL_W = 16;

  // Widths of the row and column fields on the ports.
  localparam int FIELD_ROW_W = 5;
  localparam int FIELD_COL_W = 7;

  localparam logic [7:0] NEWLINE_BYTE = 8'd10;
  localparam logic [7:0] BLANK_BYTE   = 8'h20;
  localparam logic [7:0] RESET_ATTR   = 8'h0F;

  localparam logic FUNC_PUT  = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_RWAIT,
    ST_SCROLL,
    ST_DONE
  } state_t;

  // Screen access in logical coordinates, before the row rotation.
  typedef struct packed {
    logic              we;
    logic              re;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [CELL_W-1:0] data;
  } mem_cmd_t;

  // Screen access at a physical cell address.
  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [CELL_W-1:0] data;
  } mem_req_t;

  typedef struct packed {
    logic [CELL_W-1:0]      cell_value;
    logic [FIELD_ROW_W-1:0] row;
    logic [FIELD_COL_W-1:0] col;
    logic                   scrolled;
  } result_t;

endpackage

`default_nettype wire

// File: hdl/text_mode_terminal_writer.sv
`default_nettype none

// Text-mode terminal writer: an 80 by 25 screen of 16-bit cells (character in
// the low byte, attribute in the high byte) with a cursor. A put request
// (tuser 0) writes the character at the cursor and advances it, or moves to
// the next row on a newline; running past the bottom row scrolls the screen
// by rotating a top-row offset and filling the freed row with blanks in the
// current attribute. A read request (tuser 1) returns one cell, or zero when
// the position is off the screen. Every request gives one result with the
// cursor after the request. After reset the block clears all 2000 cells, one
// per cycle, and takes no request until the clear is done. A request is taken
// only when the sequencer is idle; a read waits on the screen memory, which
// has a registered read port, and a put that scrolls also refills the bottom
// row with blanks one cell per cycle through the shared address unit. The
// result register lets the next request in while a result waits to be taken.
module text_mode_terminal_writer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,   // text_attribute
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,       // char_code[7:0], read_row[12:8], read_col[19:13]
  input  logic        s_tuser,       // func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata        // cell_value[15:0], cursor_row[20:16],
                                     // cursor_col[27:21], scrolled[28]
);

  logic [7:0]                    text_attribute;
  tmtw_pkg::mem_cmd_t            cmd;
  tmtw_pkg::mem_req_t            req;
  logic [tmtw_pkg::ROW_W-1:0]    top_row;
  logic [tmtw_pkg::CELL_W-1:0]   rdata;
  tmtw_pkg::result_t             result;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_attribute <= tmtw_pkg::RESET_ATTR;
    end else if (cfg_wr_en) begin
      text_attribute <= cfg_wr_data;
    end
  end

  tmtw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_valid  (s_tvalid),
    .s_ready  (s_tready),
    .in_func  (s_tuser),
    .in_char  (s_tdata[7:0]),
    .in_row   (s_tdata[12:8]),
    .in_col   (s_tdata[19:13]),
    .attr     (text_attribute),
    .cmd      (cmd),
    .top_row  (top_row),
    .rdata    (rdata),
    .m_valid  (m_tvalid),
    .m_ready  (m_tready),
    .result   (result)
  );

  tmtw_addr_unit u_addr (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .top_row  (top_row),
    .req      (req)
  );

  tmtw_screen_ram u_ram (
    .clk      (clk),
    .req      (req),
    .rdata    (rdata)
  );

  assign m_tdata = {3'b000, result.scrolled, result.col, result.row, result.cell_value};

endmodule

`default_nettype wire

// File: hdl/tmtw_addr_unit.sv
`default_nettype none

// Shared address stage: maps a logical row through the rotating top-row
// offset to a physical row, then forms row * width + column. Every screen
// access of the block passes through here and is registered on the way out.
module tmtw_addr_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  tmtw_pkg::mem_cmd_t        cmd,
  input  logic [tmtw_pkg::ROW_W-1:0] top_row,
  output tmtw_pkg::mem_req_t        req
);

  logic [tmtw_pkg::ROW_W:0]    row_sum;
  logic [tmtw_pkg::ROW_W-1:0]  phys_row;
  logic [tmtw_pkg::ADDR_W-1:0] addr;

  always_comb begin
    row_sum = {1'b0, cmd.row} + {1'b0, top_row};
    if (row_sum >= (tmtw_pkg::ROW_W + 1)'(tmtw_pkg::SCREEN_HEIGHT)) begin
      row_sum = row_sum - (tmtw_pkg::ROW_W + 1)'(tmtw_pkg::SCREEN_HEIGHT);
    end
    phys_row = row_sum[tmtw_pkg::ROW_W-1:0];
    addr = tmtw_pkg::ADDR_W'(phys_row) * tmtw_pkg::ADDR_W'(tmtw_pkg::SCREEN_WIDTH)
         + tmtw_pkg::ADDR_W'(cmd.col);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req.we <= 1'b0;
      req.re <= 1'b0;
    end else begin
      req.we <= cmd.we;
      req.re <= cmd.re;
    end
    req.addr <= addr;
    req.data <= cmd.data;
  end

endmodule

`default_nettype wire

// File: hdl/tmtw_screen_ram.sv
`default_nettype none

// Screen memory, one write and one read per cycle, registered read data.
module tmtw_screen_ram (
  input  logic                          clk,
  input  tmtw_pkg::mem_req_t            req,
  output logic [tmtw_pkg::CELL_W-1:0]   rdata
);

  logic [tmtw_pkg::CELL_W-1:0] mem [tmtw_pkg::CELLS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.data;
    end
    if (req.re) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

`default_nettype wire

// File: hdl/tmtw_ctrl.sv
`default_nettype none

`include "text_mode_terminal_writer_assert.svh"

// Sequencer: clears the screen after reset, runs one request at a time
// through the address unit, sweeps the freed row on a scroll and holds the
// result in an output register.
module tmtw_ctrl (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_valid,
  output logic                                 s_ready,
  input  logic                                 in_func,
  input  logic [7:0]                           in_char,
  input  logic [tmtw_pkg::FIELD_ROW_W-1:0]     in_row,
  input  logic [tmtw_pkg::FIELD_COL_W-1:0]     in_col,
  input  logic [7:0]                           attr,
  output tmtw_pkg::mem_cmd_t                   cmd,
  output logic [tmtw_pkg::ROW_W-1:0]           top_row,
  input  logic [tmtw_pkg::CELL_W-1:0]          rdata,
  output logic                                 m_valid,
  input  logic                                 m_ready,
  output tmtw_pkg::result_t                    result
);

  localparam logic [tmtw_pkg::ROW_W-1:0] LAST_ROW =
    tmtw_pkg::ROW_W'(tmtw_pkg::SCREEN_HEIGHT - 1);
  localparam logic [tmtw_pkg::COL_W-1:0] LAST_COL =
    tmtw_pkg::COL_W'(tmtw_pkg::SCREEN_WIDTH - 1);

  tmtw_pkg::state_t state, state_next;

  logic [tmtw_pkg::ROW_W-1:0]       cur_row;
  logic [tmtw_pkg::COL_W-1:0]       cur_col;
  logic [tmtw_pkg::ROW_W-1:0]       sweep_row;
  logic [tmtw_pkg::COL_W-1:0]       sweep_col;
  logic                             item_func;
  logic [7:0]                       item_char;
  logic [tmtw_pkg::FIELD_ROW_W-1:0] item_row;
  logic [tmtw_pkg::FIELD_COL_W-1:0] item_col;
  logic                             scrolled;

  logic accept;
  logic out_load;
  logic is_read;
  logic is_newline;
  logic in_range;
  logic need_next_row;
  logic do_scroll;
  logic out_free;

  assign accept   = s_valid && s_ready;
  assign out_free = !m_valid || m_ready;

  always_comb begin
    is_read    = (item_func == tmtw_pkg::FUNC_READ);
    is_newline = (item_char == tmtw_pkg::NEWLINE_BYTE);
    in_range   = (int'(item_row) < tmtw_pkg::SCREEN_HEIGHT) &&
                 (int'(item_col) < tmtw_pkg::SCREEN_WIDTH);
    need_next_row = !is_read && (is_newline || (cur_col == LAST_COL));
    do_scroll     = need_next_row && (cur_row == LAST_ROW);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tmtw_pkg::ST_CLEAR: begin
        if ((sweep_row == LAST_ROW) && (sweep_col == LAST_COL)) begin
          state_next = tmtw_pkg::ST_IDLE;
        end
      end
      tmtw_pkg::ST_IDLE: begin
        if (s_valid) begin
          state_next = tmtw_pkg::ST_EXEC;
        end
      end
      tmtw_pkg::ST_EXEC: begin
        priority if (is_read && in_range) begin
          state_next = tmtw_pkg::ST_RWAIT;
        end else if (do_scroll) begin
          state_next = tmtw_pkg::ST_SCROLL;
        end else begin
          state_next = tmtw_pkg::ST_DONE;
        end
      end
      tmtw_pkg::ST_RWAIT: begin
        state_next = tmtw_pkg::ST_DONE;
      end
      tmtw_pkg::ST_SCROLL: begin
        if (sweep_col == LAST_COL) begin
          state_next = tmtw_pkg::ST_DONE;
        end
      end
      tmtw_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = tmtw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tmtw_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_ready  = 1'b0;
    out_load = 1'b0;
    cmd.we   = 1'b0;
    cmd.re   = 1'b0;
    cmd.row  = cur_row;
    cmd.col  = cur_col;
    cmd.data = {attr, item_char};
    unique case (state)
      tmtw_pkg::ST_CLEAR: begin
        cmd.we   = 1'b1;
        cmd.row  = sweep_row;
        cmd.col  = sweep_col;
        cmd.data = {tmtw_pkg::RESET_ATTR, tmtw_pkg::BLANK_BYTE};
      end
      tmtw_pkg::ST_IDLE: begin
        s_ready = 1'b1;
      end
      tmtw_pkg::ST_EXEC: begin
        if (is_read) begin
          cmd.re  = in_range;
          cmd.row = tmtw_pkg::ROW_W'(item_row);
          cmd.col = tmtw_pkg::COL_W'(item_col);
        end else begin
          cmd.we = !is_newline;
        end
      end
      tmtw_pkg::ST_RWAIT: begin
      end
      tmtw_pkg::ST_SCROLL: begin
        // The old top row is now the bottom row; fill it with blanks.
        cmd.we   = 1'b1;
        cmd.row  = LAST_ROW;
        cmd.col  = sweep_col;
        cmd.data = {attr, tmtw_pkg::BLANK_BYTE};
      end
      tmtw_pkg::ST_DONE: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tmtw_pkg::ST_CLEAR;
      cur_row   <= '0;
      cur_col   <= '0;
      top_row   <= '0;
      sweep_row <= '0;
      sweep_col <= '0;
      scrolled  <= 1'b0;
      m_valid   <= 1'b0;
    end else begin
      state <= state_next;

      if (state == tmtw_pkg::ST_CLEAR) begin
        if (sweep_col == LAST_COL) begin
          sweep_col <= '0;
          sweep_row <= sweep_row + 1'b1;
        end else begin
          sweep_col <= sweep_col + 1'b1;
        end
      end

      if (accept) begin
        scrolled <= 1'b0;
      end

      if ((state == tmtw_pkg::ST_EXEC) && !is_read) begin
        sweep_col <= '0;
        if (need_next_row) begin
          cur_col <= '0;
          if (cur_row == LAST_ROW) begin
            scrolled <= 1'b1;
            top_row  <= (top_row == LAST_ROW) ? '0 : top_row + 1'b1;
          end else begin
            cur_row <= cur_row + 1'b1;
          end
        end else begin
          cur_col <= cur_col + 1'b1;
        end
      end

      if (state == tmtw_pkg::ST_SCROLL) begin
        sweep_col <= sweep_col + 1'b1;
      end

      if (out_load) begin
        m_valid <= 1'b1;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
    end

    if (accept) begin
      item_func <= in_func;
      item_char <= in_char;
      item_row  <= in_row;
      item_col  <= in_col;
    end

    if (out_load) begin
      result.cell_value <= (is_read && in_range) ? rdata : '0;
      result.row        <= tmtw_pkg::FIELD_ROW_W'(cur_row);
      result.col        <= tmtw_pkg::FIELD_COL_W'(cur_col);
      result.scrolled   <= scrolled;
    end
  end

  `TMTW_ASSERT_SAME(a_row_on_screen, 1'b1, cur_row <= LAST_ROW)
  `TMTW_ASSERT_SAME(a_col_on_screen, 1'b1, cur_col <= LAST_COL)
  `TMTW_ASSERT_SAME(a_top_on_screen, 1'b1, top_row <= LAST_ROW)
  `TMTW_ASSERT_SAME(a_scroll_cursor, state == tmtw_pkg::ST_SCROLL,
                    (cur_row == LAST_ROW) && (cur_col == '0) && scrolled)
  `TMTW_ASSERT_NEXT(a_accept_starts, accept, state == tmtw_pkg::ST_EXEC)

endmodule

`default_nettype wire

// File: dv/text_mode_terminal_writer_test.sv
`default_nettype none

module text_mode_terminal_writer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LONG_HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES    = 16;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = 8'h00;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = 24'h0;
  logic        s_tuser = tmtw_pkg::FUNC_PUT;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;

  text_mode_terminal_writer uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),     // char_code, read_row, read_col
    .s_tuser     (s_tuser),     // func
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)      // cell_value, cursor_row, cursor_col, scrolled
  );

  always #10 clk = ~clk;

  // Screen and cursor as the block should hold them.
  logic [tmtw_pkg::CELL_W-1:0] screen_model [0:tmtw_pkg::CELLS-1];
  int                          cursor_row_model;
  int                          cursor_col_model;
  logic [7:0]                  attribute_model;
  tmtw_pkg::result_t           expected_results [$];

  int failures = 0;
  int puts_sent = 0;
  int reads_sent = 0;
  int offscreen_reads = 0;
  int attr_writes = 0;
  int scrolls_seen = 0;
  int results_checked = 0;

  bit sender_idles = 1'b1;
  int burst_left = 0;
  logic hold_request = 1'b0;
  int hold_left = 0;
  int pattern_left = 0;
  int stall_mode = 0;

  function automatic void reset_screen_model();
    for (int i = 0; i < tmtw_pkg::CELLS; i++)
      screen_model[i] = {tmtw_pkg::RESET_ATTR, tmtw_pkg::BLANK_BYTE};
    cursor_row_model = 0;
    cursor_col_model = 0;
    attribute_model = tmtw_pkg::RESET_ATTR;
  endfunction

  function automatic logic advance_row();
    cursor_col_model = 0;
    cursor_row_model++;
    if (cursor_row_model < tmtw_pkg::SCREEN_HEIGHT) return 1'b0;
    for (int i = 0; i < tmtw_pkg::CELLS - tmtw_pkg::SCREEN_WIDTH; i++)
      screen_model[i] = screen_model[i + tmtw_pkg::SCREEN_WIDTH];
    for (int i = tmtw_pkg::CELLS - tmtw_pkg::SCREEN_WIDTH; i < tmtw_pkg::CELLS; i++)
      screen_model[i] = {attribute_model, tmtw_pkg::BLANK_BYTE};
    cursor_row_model = tmtw_pkg::SCREEN_HEIGHT - 1;
    return 1'b1;
  endfunction

  function automatic tmtw_pkg::result_t predict_terminal(logic func, logic [7:0] ch,
                                                         logic [4:0] rr, logic [6:0] rc);
    tmtw_pkg::result_t r;
    r = '0;
    if (func == tmtw_pkg::FUNC_READ) begin
      if (rr < tmtw_pkg::SCREEN_HEIGHT && rc < tmtw_pkg::SCREEN_WIDTH)
        r.cell_value = screen_model[int'(rr) * tmtw_pkg::SCREEN_WIDTH + int'(rc)];
    end else if (ch == tmtw_pkg::NEWLINE_BYTE) begin
      r.scrolled = advance_row();
    end else begin
      screen_model[cursor_row_model * tmtw_pkg::SCREEN_WIDTH + cursor_col_model] =
        {attribute_model, ch};
      cursor_col_model++;
      if (cursor_col_model >= tmtw_pkg::SCREEN_WIDTH) r.scrolled = advance_row();
    end
    r.row = cursor_row_model[tmtw_pkg::FIELD_ROW_W-1:0];
    r.col = cursor_col_model[tmtw_pkg::FIELD_COL_W-1:0];
    return r;
  endfunction

  // Offers one request, random gaps between bursts if sender_idles; waits until taken.
  task automatic send_request(input logic func, input logic [7:0] ch, input logic [4:0] rr,
                              input logic [6:0] rc);
    int gap;
    if (burst_left == 0) begin
      gap = sender_idles ? $urandom_range(0, 8) : 0;
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {4'b0000, rc, rr, ch};
    expected_results.push_back(predict_terminal(func, ch, rr, rc));
    if (func == tmtw_pkg::FUNC_READ) begin
      reads_sent++;
      if (rr >= tmtw_pkg::SCREEN_HEIGHT || rc >= tmtw_pkg::SCREEN_WIDTH) offscreen_reads++;
    end else begin
      puts_sent++;
    end
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_attribute(input logic [7:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    attribute_model = value;
    attr_writes++;
  endtask

  task automatic random_request();
    int   pick;
    logic func;
    logic [7:0] ch;
    logic [4:0] rr;
    logic [6:0] rc;
    pick = $urandom_range(0, 99);
    func = tmtw_pkg::FUNC_PUT;
    ch = 8'($urandom_range(0, 255));
    rr = 5'($urandom_range(0, 31));
    rc = 7'($urandom_range(0, 127));
    if (pick < 55) begin
      ch = 8'($urandom_range(32, 126));
    end else if (pick < 70) begin
      ch = tmtw_pkg::NEWLINE_BYTE;
    end else if (pick < 90) begin
      func = tmtw_pkg::FUNC_READ;
      // Half of these reads look at the cursor row, where the fresh writes are.
      rr = ($urandom_range(0, 1) == 1) ? 5'(cursor_row_model)
                                       : 5'($urandom_range(0, tmtw_pkg::SCREEN_HEIGHT - 1));
      rc = 7'($urandom_range(0, tmtw_pkg::SCREEN_WIDTH - 1));
    end else if (pick < 95) begin
      func = tmtw_pkg::FUNC_READ;
    end
    send_request(func, ch, rr, rc);
  endtask

  task automatic test_reset_screen();
    send_request(tmtw_pkg::FUNC_READ, 8'h00, 5'd0, 7'd0);
    send_request(tmtw_pkg::FUNC_READ, 8'hFF, 5'(tmtw_pkg::SCREEN_HEIGHT - 1),
                 7'(tmtw_pkg::SCREEN_WIDTH - 1));
    send_request(tmtw_pkg::FUNC_READ, 8'h00, 5'(tmtw_pkg::SCREEN_HEIGHT), 7'd0);
    send_request(tmtw_pkg::FUNC_READ, 8'hFF, 5'd31, 7'd127);
    wait_for_results();
  endtask

  task automatic test_attribute_extremes();
    write_attribute(8'hFF);
    send_request(tmtw_pkg::FUNC_PUT, 8'h00, 5'd31, 7'd127);
    wait_for_results();
    write_attribute(8'h00);
    send_request(tmtw_pkg::FUNC_PUT, 8'hFF, 5'd0, 7'd0);
    send_request(tmtw_pkg::FUNC_READ, 8'h00, 5'd0, 7'd0);
    send_request(tmtw_pkg::FUNC_READ, 8'h00, 5'd0, 7'd1);
    wait_for_results();
  endtask

  // Newlines down to the bottom row, then one more that must scroll and blank
  // the bottom row in the attribute of the moment.
  task automatic test_newline_scroll();
    write_attribute(8'h5A);
    while (cursor_row_model < tmtw_pkg::SCREEN_HEIGHT - 1)
      send_request(tmtw_pkg::FUNC_PUT, tmtw_pkg::NEWLINE_BYTE, 5'($urandom_range(0, 31)),
                   7'($urandom_range(0, 127)));
    send_request(tmtw_pkg::FUNC_PUT, tmtw_pkg::NEWLINE_BYTE, 5'd0, 7'd0);
    send_request(tmtw_pkg::FUNC_READ, 8'h00, 5'(tmtw_pkg::SCREEN_HEIGHT - 1), 7'd0);
    send_request(tmtw_pkg::FUNC_READ, 8'h00, 5'd0, 7'd0);
    wait_for_results();
  endtask

  task automatic test_random_traffic(input int count, input logic [7:0] attr, input bit idles);
    write_attribute(attr);
    sender_idles = idles;
    repeat (count) random_request();
    wait_for_results();
    sender_idles = 1'b1;
  endtask

  // The receiver holds off for a long stretch while requests keep coming, so the
  // block fills up and has to stall its input.
  task automatic test_backpressure();
    @(posedge clk);
    hold_request <= 1'b1;
    @(posedge clk);
    hold_request <= 1'b0;
    sender_idles = 1'b0;
    repeat (40) random_request();
    wait_for_results();
    sender_idles = 1'b1;
  endtask

  always @(posedge clk) begin
    if (hold_request) begin
      hold_left <= LONG_HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      if (pattern_left == 0) begin
        stall_mode   <= $urandom_range(0, 2);
        pattern_left <= $urandom_range(20, 200);
      end else begin
        pattern_left <= pattern_left - 1;
      end
      case (stall_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= 1'($urandom_range(0, 1));
        default: m_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    tmtw_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: m_tdata %h", m_tdata);
        failures++;
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (m_tdata[15:0] !== want.cell_value) begin
          $error("cell_value expected %h actual %h", want.cell_value, m_tdata[15:0]);
          failures++;
        end
        if (m_tdata[20:16] !== want.row) begin
          $error("cursor_row expected %0d actual %0d", want.row, m_tdata[20:16]);
          failures++;
        end
        if (m_tdata[27:21] !== want.col) begin
          $error("cursor_col expected %0d actual %0d", want.col, m_tdata[27:21]);
          failures++;
        end
        if (m_tdata[28] !== want.scrolled) begin
          $error("scrolled expected %0d actual %0d", want.scrolled, m_tdata[28]);
          failures++;
        end
        if (m_tdata[28] === 1'b1) scrolls_seen++;
      end
    end
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    reset_screen_model();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_reset_screen();
    test_attribute_extremes();
    test_newline_scroll();
    test_random_traffic(350, 8'hFF, 1'b0);
    test_random_traffic(350, 8'($urandom_range(0, 255)), 1'b1);
    test_backpressure();
    test_random_traffic(350, 8'h00, 1'b1);
    test_random_traffic(350, tmtw_pkg::RESET_ATTR, 1'b1);
    repeat (100) @(posedge clk);
    $display("checked %0d results: %0d puts, %0d reads (%0d off screen), %0d scrolls",
             results_checked, puts_sent, reads_sent, offscreen_reads, scrolls_seen);
    $display("attribute written %0d times, including both extremes", attr_writes);
    if (failures == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
